[design/mbps_pkg.sv]
// Package for the masked byte pattern scanner.
// Holds the register index codes, field widths and the per-cell setup struct.
// No dependencies.
package mbps_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int ADDR_BITS      = 64;
   localparam int LENGTH_BITS    = 5;
   localparam int MASK_BITS      = 16;
   localparam int PATTERN_BYTES  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LOW    = 3'd0,
      REG_PATTERN_HIGH   = 3'd1,
      REG_CARE_MASK      = 3'd2,
      REG_PATTERN_LENGTH = 3'd3,
      REG_REGION_BASE    = 3'd4
   } csr_reg_type;

   // Setup of one window cell: which pattern byte it is compared against.
   typedef struct packed {
      logic       active;
      logic       care;
      logic [7:0] pattern;
   } cell_cfg_type;

endpackage

[design/mbps_cell.sv]
// One cell of the byte window chain: a byte register and its masked compare.
// Depends on mbps_pkg.
module mbps_cell
   import mbps_pkg::*;
(
   input  logic         clock,
   input  logic         shift_en,
   input  logic [7:0]   byte_in,
   input  cell_cfg_type cfg,
   output logic [7:0]   byte_out,
   output logic         hit
);

   logic [7:0] byte_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   // The compare looks at the byte entering this cell, which is the cell's
   // contents once the current request has been shifted in.
   assign hit      = !cfg.active || !cfg.care || (byte_in == cfg.pattern);
   assign byte_out = byte_ff;

endmodule

[design/masked_byte_pattern_scanner_top.sv]
// Top level of the masked byte pattern scanner.
// Depends on mbps_pkg and mbps_cell; the checker in mbps_checker binds to it.
//
// The scanner takes one byte of a memory region per request, in address order,
// and looks for the first place where a pattern of up to MAX_PATTERN_BYTES
// bytes matches; pattern bytes whose care_mask bit is clear match any byte.
// Software writes the pattern, the care mask, the pattern length (zero
// matches at the base on the first byte, values above MAX_PATTERN_BYTES act
// as MAX_PATTERN_BYTES) and the region base through the csr_ port while no
// region is in flight. On the first match one response comes out with
// rsp_tuser (found) high and rsp_tdata holding region_base plus the match
// start offset, wrapping at 64 bits. Later bytes of that region are consumed
// silently. A region whose last byte (req_tlast) arrives without a match
// produces one response with found low and a zero address; a region shorter
// than the pattern always ends that way. The byte offset counter is
// OFFSET_BITS wide and saturates; bytes at the saturated offset and beyond
// are no longer searched as match ends. The bytes move through a chain of
// MAX_PATTERN_BYTES cells, each comparing its byte in parallel, and a single
// output register holds the response, so a new byte is accepted in every
// cycle in which that register is empty or is being drained. Responses are
// registered and appear in the cycle after the request that caused them.
module masked_byte_pattern_scanner_top
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // Configuration write port.
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] data_byte
   input  logic                      req_tlast,   // last_byte
   // Response channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [ADDR_BITS-1:0]      rsp_tdata,   // [63:0] match_address
   output logic                      rsp_tuser    // found
);

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] MAX_LEN   = LENGTH_BITS'(MAX_PATTERN_BYTES);

   // Configuration registers.
   logic [63:0]            pattern_low_ff;
   logic [63:0]            pattern_high_ff;
   logic [MASK_BITS-1:0]   care_mask_ff;
   logic [LENGTH_BITS-1:0] pattern_length_ff;
   logic [ADDR_BITS-1:0]   region_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= '0;
         region_base_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            REG_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            REG_CARE_MASK:      care_mask_ff      <= csr_wdata[MASK_BITS-1:0];
            REG_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LENGTH_BITS-1:0];
            REG_REGION_BASE:    region_base_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Region state and the response register.
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   reported_ff, reported_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [ADDR_BITS-1:0]   rsp_addr_ff, rsp_addr_in;

   logic accept;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Effective pattern length and the pattern as a byte array.
   logic [LENGTH_BITS-1:0]              len_eff;
   logic [LENGTH_BITS-1:0]              len_m1;
   logic [PATTERN_BYTES-1:0][7:0]       pat_bytes;

   assign len_eff   = (pattern_length_ff > MAX_LEN) ? MAX_LEN : pattern_length_ff;
   assign len_m1    = len_eff - LENGTH_BITS'(1);
   assign pat_bytes = {pattern_high_ff, pattern_low_ff};

   // Chain of window cells. Cell j compares the byte that arrived j requests ago
   // (the byte it takes in on acceptance) against pattern byte len-1-j.
   logic [MAX_PATTERN_BYTES-1:0][7:0] win_byte;
   logic [MAX_PATTERN_BYTES-1:0]      cell_hit;

   for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
      logic [LENGTH_BITS-1:0] pat_pos;
      logic [3:0]             pat_idx;
      logic [7:0]             byte_in;
      cell_cfg_type           cfg;

      assign pat_pos     = len_m1 - LENGTH_BITS'(j);
      assign pat_idx     = pat_pos[3:0];
      assign cfg.active  = LENGTH_BITS'(j) < len_eff;
      assign cfg.care    = care_mask_ff[pat_idx];
      assign cfg.pattern = pat_bytes[pat_idx];

      if (j == 0) begin : g_head
         assign byte_in = req_tdata;
      end else begin : g_link
         assign byte_in = win_byte[j-1];
      end

      mbps_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .byte_in  (byte_in),
         .cfg      (cfg),
         .byte_out (win_byte[j]),
         .hit      (cell_hit[j])
      );
   end

   // Match decision for the byte being accepted.
   logic                   searchable;
   logic                   len_zero;
   logic                   hit;
   logic [OFFSET_BITS-1:0] start_offset;
   logic [ADDR_BITS-1:0]   match_addr;

   assign len_zero   = (len_eff == '0);
   assign searchable = !reported_ff && (offset_ff != OFFSET_MAX);
   assign hit = searchable &&
                (len_zero ? (offset_ff == '0)
                          : ((offset_ff >= OFFSET_BITS'(len_m1)) && (&cell_hit)));
   // The match ending at offset cur starts at cur + 1 - len.
   assign start_offset = len_zero ? '0 : (offset_ff - OFFSET_BITS'(len_m1));
   assign match_addr   = region_base_ff + ADDR_BITS'(start_offset);

   always_comb begin
      offset_in    = offset_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (accept) begin
         if (req_tlast) begin
            offset_in   = '0;
            reported_in = 1'b0;
         end else begin
            offset_in   = (offset_ff == OFFSET_MAX) ? offset_ff
                                                    : offset_ff + OFFSET_BITS'(1);
            reported_in = reported_ff || hit;
         end
         if (hit || (req_tlast && !reported_ff)) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = hit;
            rsp_addr_in  = hit ? match_addr : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_addr_ff;

endmodule

[design/mbps_checker.sv]
// Port-level checks for the masked byte pattern scanner, bound to its top.
// Depends on mbps_pkg and masked_byte_pattern_scanner_top.
module mbps_checker
   import mbps_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [ADDR_BITS-1:0] rsp_tdata,
   input logic                 rsp_tuser
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A not-found response carries a zero address.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("not-found response with nonzero address");

   // No request is taken while a response waits with nowhere to go.
   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while response stalled");

   // A new response only follows an accepted request.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("response without a request");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/masked_byte_pattern_scanner_top_test.sv]
// Self-checking testbench for masked_byte_pattern_scanner_top; depends on it
// and on mbps_pkg. Streams byte regions with random gaps and response stalls,
// predicts each response in a local scanner model and compares it.
module masked_byte_pattern_scanner_top_test;
   import mbps_pkg::*;

   // The scanner is built with its default sizes; the local model mirrors them.
   localparam int SCAN_BYTES   = 16;
   localparam int OFFSET_BITS  = 32;
   localparam int RANDOM_BYTES = 1420;
   localparam int LIMIT_CYCLES = 600000;
   localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT = {OFFSET_BITS{1'b1}};

   // One response: found flag and match address.
   typedef struct packed {
      logic                 found;
      logic [ADDR_BITS-1:0] address;
   } scan_result_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;   // [7:0] data_byte
   logic                      req_tlast  = 1'b0; // last_byte
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [ADDR_BITS-1:0]      rsp_tdata;         // [63:0] match_address
   logic                      rsp_tuser;         // found

   // Mirror of the configuration registers as the scanner should hold them.
   logic [8*PATTERN_BYTES-1:0] pattern_bits   = '0;
   logic [MASK_BITS-1:0]       care_bits      = '0;
   logic [LENGTH_BITS-1:0]     length_setting = '0;
   logic [ADDR_BITS-1:0]       base_address   = '0;

   // Mirror of the scan state of the region in flight.
   logic [7:0]             window [SCAN_BYTES];
   logic [OFFSET_BITS-1:0] offset   = '0;
   bit                     reported = 1'b0;

   // Responses predicted but not yet seen, oldest first.
   scan_result_type pending_results [$];
   // Bytes of the next region to be streamed.
   logic [7:0]   region_bytes [$];

   int           error_count = 0;
   int           cycle_count = 0;
   int           stall_left  = 0;
   // When set, neither side inserts gaps, so requests go back to back.
   bit           steady      = 1'b0;
   scan_result_type oldest;

   masked_byte_pattern_scanner_top #(
      .MAX_PATTERN_BYTES(SCAN_BYTES),
      .OFFSET_BITS      (OFFSET_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Gap length for either side: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   // A length setting above the window size behaves as the full window.
   function automatic int active_length();
      return (length_setting > SCAN_BYTES) ? SCAN_BYTES : int'(length_setting);
   endfunction

   function automatic logic [7:0] pattern_byte(input int idx);
      return pattern_bits[8*idx +: 8];
   endfunction

   // Appends one predicted response at the young end of the queue.
   function automatic void expect_result(input logic found, input logic [ADDR_BITS-1:0] addr);
      scan_result_type item;
      item.found   = found;
      item.address = addr;
      pending_results.insert(pending_results.size(), item);
   endfunction

   // Starts a fresh region: empty window, offset zero, nothing reported yet.
   function automatic void clear_region();
      for (int i = 0; i < SCAN_BYTES; i++) begin
         window[i] = 8'h00;
      end
      offset   = '0;
      reported = 1'b0;
   endfunction

   // Advances the scan state by one accepted byte and queues the response
   // that this byte should cause, if any.
   function automatic void scan_byte(input logic [7:0] value, input bit last);
      int                   plen;
      bit                   hit;
      logic [ADDR_BITS-1:0] start;
      plen = active_length();
      for (int i = SCAN_BYTES - 1; i > 0; i--) begin
         window[i] = window[i-1];
      end
      window[0] = value;
      // Once the offset has saturated, no byte can end a match any more.
      if (!reported && offset != OFFSET_LIMIT) begin
         hit   = 1'b0;
         start = '0;
         if (plen == 0) begin
            // An empty pattern matches at the base on the first byte.
            hit = (offset == '0);
         end else if (ADDR_BITS'(offset) + 1 >= ADDR_BITS'(plen)) begin
            // Pattern byte 0 sits at the oldest position of the window.
            hit = 1'b1;
            for (int i = 0; i < plen; i++) begin
               if (care_bits[i] && window[plen-1-i] != pattern_byte(i)) begin
                  hit = 1'b0;
               end
            end
            start = ADDR_BITS'(offset) + 1 - ADDR_BITS'(plen);
         end
         if (hit) begin
            reported = 1'b1;
            expect_result(1'b1, base_address + start);
         end
      end
      if (offset != OFFSET_LIMIT) begin
         offset++;
      end
      if (last) begin
         // A match on the last byte stands alone; otherwise report not found.
         if (!reported) begin
            expect_result(1'b0, '0);
         end
         clear_region();
      end
   endfunction

   // Response side: stalls at random, and every accepted response is
   // compared with the oldest prediction.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, found %0b address %h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tuser !== oldest.found) begin
               $display("%0t: found mismatch, expected %0b actual %0b",
                        $time, oldest.found, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== oldest.address) begin
               $display("%0t: match address mismatch, expected %h actual %h",
                        $time, oldest.address, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d responses outstanding",
                  $time, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Sends one request after a random gap and waits for its acceptance.
   // Returns at the edge that accepted it, with tvalid still high, so that
   // the next request can follow without a bubble.
   task automatic send_byte(input logic [7:0] value, input bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      scan_byte(value, last);
   endtask

   // Stops sending and waits until every predicted response has come out.
   // It always waits on the clock with tvalid low, so a bubble comes before
   // the next request.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Streams region_bytes with tlast on the final byte. If pause_at names a
   // byte, the sender first waits for all outstanding responses.
   task automatic send_region(input int pause_at);
      for (int i = 0; i < region_bytes.size(); i++) begin
         if (i == pause_at) begin
            drain_results();
         end
         send_byte(region_bytes[i], i == region_bytes.size() - 1);
      end
   endtask

   // Writes all five registers one after another. Only called with the
   // scanner idle: a byte that causes no response may still be in the
   // pipeline, so the task idles after the last response before writing.
   task automatic program_scanner(input logic [63:0] low_word, input logic [63:0] high_word,
                                  input logic [63:0] mask_word, input logic [63:0] length_word,
                                  input logic [63:0] base_word);
      csr_reg_type order [5];
      logic [63:0] words [5];
      order = '{REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_CARE_MASK,
                REG_PATTERN_LENGTH, REG_REGION_BASE};
      words = '{low_word, high_word, mask_word, length_word, base_word};
      drain_results();
      repeat (4) @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= words[i];
         @(posedge clock);
         // Registers keep only their own width; upper data bits are dropped.
         unique case (order[i])
            REG_PATTERN_LOW:    pattern_bits[63:0]   = words[i];
            REG_PATTERN_HIGH:   pattern_bits[127:64] = words[i];
            REG_CARE_MASK:      care_bits            = words[i][MASK_BITS-1:0];
            REG_PATTERN_LENGTH: length_setting       = words[i][LENGTH_BITS-1:0];
            REG_REGION_BASE:    base_address         = words[i];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // After reset the pattern is empty, so each region matches at base zero
   // on its first byte, including a region of a single byte.
   task automatic test_empty_pattern();
      region_bytes = '{8'hA5};
      send_region(-1);
      region_bytes = '{8'h00, 8'hFF};
      send_region(-1);
   endtask

   // A region shorter than the pattern can never match.
   task automatic test_short_region();
      program_scanner(64'h0000_0000_0033_2211, 64'h0, 64'hFFFF, 64'd3, 64'h1000);
      region_bytes = '{8'h11, 8'h22};
      send_region(-1);
   endtask

   // Match found on the last byte of the region with a base that wraps the
   // address around zero: only the found response may appear.
   task automatic test_wrap_on_last_byte();
      program_scanner(64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3, 64'd2,
                      64'hFFFF_FFFF_FFFF_FFFF);
      region_bytes = '{8'h00, 8'hFF, 8'h00};
      send_region(-1);
   endtask

   // A length setting of 31 acts as a full 16-byte window; with every
   // position a wildcard it matches when the sixteenth byte arrives.
   // Junk in the upper data bits of the length and mask writes is ignored.
   task automatic test_long_length();
      program_scanner(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_0000,
                      64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
      region_bytes.delete();
      for (int i = 0; i < 16; i++) begin
         region_bytes.insert(region_bytes.size(), (i % 2 == 0) ? 8'h00 : 8'hFF);
      end
      send_region(-1);
   endtask

   // The sender holds off mid-region until the match response has drained.
   task automatic test_drain_pause();
      program_scanner(64'h5A, 64'h0, 64'h1, 64'd1, 64'd7);
      region_bytes = '{8'h11, 8'h5A, 8'h22, 8'h33};
      send_region(2);
   endtask

   // Random register settings, the extremes weighted up.
   task automatic program_random();
      logic [63:0] low_word, high_word, mask_word, length_word, base_word;
      int roll;
      low_word  = {$urandom, $urandom};
      high_word = {$urandom, $urandom};
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         low_word  = '0;
         high_word = '1;
      end else if (roll == 1) begin
         low_word  = '1;
         high_word = '0;
      end
      roll = $urandom_range(0, 99);
      mask_word = (roll < 15) ? 64'h0 : (roll < 35) ? 64'hFFFF : {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         mask_word[63:MASK_BITS] = '0;
      end
      roll = $urandom_range(0, 99);
      length_word = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         length_word = '0;
      end
      length_word[LENGTH_BITS-1:0] = (roll < 8)  ? 5'd0 :
                                     (roll < 70) ? 5'($urandom_range(1, 6)) :
                                     (roll < 88) ? 5'($urandom_range(7, 16)) :
                                                   5'($urandom_range(17, 31));
      roll = $urandom_range(0, 99);
      base_word = (roll < 10) ? 64'h0 :
                  (roll < 20) ? 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40) :
                                {$urandom, $urandom};
      program_scanner(low_word, high_word, mask_word, length_word, base_word);
   endtask

   // Builds the next random region. Most regions carry the pattern at a
   // random place (wildcards random), some are shorter than the pattern and
   // the rest is noise. Noise bytes lean on the pattern's own bytes so that
   // partial and overlapping matches come up often.
   task automatic build_random_region();
      int plen, roll, count, pos;
      plen = active_length();
      roll = $urandom_range(0, 99);
      region_bytes.delete();
      if (roll < 15 && plen > 1) begin
         count = $urandom_range(1, plen - 1);
      end else if ($urandom_range(0, 24) == 0) begin
         count = $urandom_range(40, 120);
      end else begin
         count = $urandom_range(1, 20) + plen;
      end
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1) == 1) begin
            region_bytes.insert(region_bytes.size(),
                                pattern_byte($urandom_range(0, SCAN_BYTES - 1)));
         end else begin
            region_bytes.insert(region_bytes.size(), 8'($urandom_range(0, 255)));
         end
      end
      if (roll >= 15 && roll < 80 && count >= plen) begin
         // Sometimes planted twice, so the earlier one has to win.
         for (int k = 0; k < (($urandom_range(0, 3) == 0) ? 2 : 1); k++) begin
            pos = $urandom_range(0, count - plen);
            for (int i = 0; i < plen; i++) begin
               if (care_bits[i]) begin
                  region_bytes[pos + i] = pattern_byte(i);
               end
            end
         end
      end
   endtask

   // Random regions under random settings, reprogrammed every few regions.
   // Some regions run with no idling on either side.
   task automatic test_random_regions();
      int sent, regions;
      sent    = 0;
      regions = 0;
      while (sent < RANDOM_BYTES) begin
         if (regions % 4 == 0) begin
            program_random();
         end
         steady = ($urandom_range(0, 7) == 0);
         build_random_region();
         send_region(($urandom_range(0, 29) == 0) ?
                     $urandom_range(0, region_bytes.size() - 1) : -1);
         sent += region_bytes.size();
         regions++;
      end
      steady = 1'b0;
   endtask

   initial begin
      clear_region();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_pattern();
      test_short_region();
      test_wrap_on_last_byte();
      test_long_length();
      test_drain_pause();
      test_random_regions();
      // Let any stray response show up before the verdict.
      drain_results();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
